// ----- src/byte_radix_text_codec_macros.svh -----
// Assertion macros for the byte radix text codec RTL.
// Included by brtc_back for its concurrent assertions; no other dependencies.
`ifndef BYTE_RADIX_TEXT_CODEC_MACROS_SVH
`define BYTE_RADIX_TEXT_CODEC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRTC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("brtc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BRTC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("brtc assertion failed");

`endif

// ----- src/brtc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the byte radix text codec: codes, the queue command type and
// the digit helper functions. No dependencies.
package brtc_pkg;

	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] MODE_BIN = 2'd0;
	localparam logic [1:0] MODE_OCT = 2'd1;
	localparam logic [1:0] MODE_DEC = 2'd2;
	localparam logic [1:0] MODE_HEX = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 1'b1;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;

	// One unit of work for the back end: either a full digit string to
	// print, or a single decoded byte.
	typedef struct packed {
		logic            is_encode;
		logic [7:0]      data;
		logic [3:0]      width;
		logic [7:0][3:0] digits;   // digits[0] is printed first
	} cmd_t;

	function automatic logic [3:0] width_of(input logic [1:0] mode);
		logic [3:0] w;
		case (mode)
			MODE_BIN: w = 4'd8;
			MODE_OCT: w = 4'd3;
			MODE_DEC: w = 4'd3;
			default:  w = 4'd2;
		endcase
		return w;
	endfunction

	// Accumulator times the radix, modulo 1024.
	function automatic logic [9:0] scale_by_radix(input logic [9:0] v, input logic [1:0] mode);
		logic [9:0] r;
		case (mode)
			MODE_BIN: r = {v[8:0], 1'b0};
			MODE_OCT: r = {v[6:0], 3'b000};
			MODE_DEC: r = {v[6:0], 3'b000} + {v[8:0], 1'b0};
			default:  r = {v[5:0], 4'b0000};
		endcase
		return r;
	endfunction

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c inside {[8'h30:8'h39]}) begin
			d = c - CHAR_ZERO;
		end else if (c inside {[8'h41:8'h46]}) begin
			d = c - CHAR_UPPER_A + 8'd10;
		end else if (c inside {[8'h61:8'h66]}) begin
			d = c - CHAR_LOWER_A + 8'd10;
		end
		return d[3:0];
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'b0000, d};
		end else begin
			c = CHAR_UPPER_A + {4'b0000, d} - 8'd10;
		end
		return c;
	endfunction

	// Splits a byte into its zero-padded digits, most significant first.
	// Decimal uses a compare for the hundreds and a reciprocal multiply
	// (x * 205 >> 11) for the tens, exact for the remainder below 100.
	function automatic logic [7:0][3:0] encode_digits(input logic [7:0] v,
			input logic [1:0] mode);
		logic [7:0][3:0] dg;
		logic [1:0]      hund;
		logic [7:0]      rem;
		logic [14:0]     prod;
		logic [3:0]      tens;
		logic [7:0]      ones;
		dg   = '0;
		hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		rem  = v - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
		prod = {7'b0, rem} * 15'd205;
		tens = prod[14:11];
		ones = rem - {tens, 3'b000} - {3'b000, tens, 1'b0};
		case (mode)
			MODE_BIN: begin
				for (int i = 0; i < 8; i++) begin
					dg[i] = {3'b000, v[7-i]};
				end
			end
			MODE_OCT: begin
				dg[0] = {2'b00, v[7:6]};
				dg[1] = {1'b0, v[5:3]};
				dg[2] = {1'b0, v[2:0]};
			end
			MODE_DEC: begin
				dg[0] = {2'b00, hund};
				dg[1] = tens;
				dg[2] = ones[3:0];
			end
			default: begin
				dg[0] = v[7:4];
				dg[1] = v[3:0];
			end
		endcase
		return dg;
	endfunction

endpackage

// ----- src/brtc_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the byte radix text codec channels.
// No dependencies.
interface brtc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface brtc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;

	modport source (output valid, output out_char, output last, input ready);
	modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ----- src/brtc_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input transfers, splits encode bytes into digits and
// accumulates decode groups. Depends on brtc_pkg and brtc_in_if.
module brtc_front (
	input  logic              clk,
	input  logic              arst_n,
	brtc_in_if.sink           in_ch,
	input  logic [1:0]        radix_mode,
	input  logic              direction,
	input  logic              q_full,
	output logic              push,
	output brtc_pkg::cmd_t    push_cmd
);

	logic [9:0] group_value_q;
	logic [3:0] group_digits_q;
	logic       accept;
	logic [9:0] next_value;
	logic [3:0] next_digits;
	logic [3:0] width;
	logic       group_done;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign width       = brtc_pkg::width_of(radix_mode);
	assign next_value  = brtc_pkg::scale_by_radix(group_value_q, radix_mode)
		+ {6'b000000, brtc_pkg::digit_value(in_ch.in_byte)};
	assign next_digits = group_digits_q + 4'd1;
	assign group_done  = next_digits >= width;

	always_comb begin
		push_cmd           = '0;
		push_cmd.width     = width;
		push_cmd.digits    = brtc_pkg::encode_digits(in_ch.in_byte, radix_mode);
		push_cmd.is_encode = (direction == brtc_pkg::DIR_ENCODE);
		push_cmd.data      = next_value[7:0];
		push               = 1'b0;
		if (accept) begin
			if (direction == brtc_pkg::DIR_ENCODE) begin
				push = 1'b1;
			end else if (in_ch.in_byte != brtc_pkg::CHAR_SPACE) begin
				push = group_done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_value_q  <= '0;
			group_digits_q <= '0;
		end else if (accept && direction == brtc_pkg::DIR_DECODE
				&& in_ch.in_byte != brtc_pkg::CHAR_SPACE) begin
			if (group_done) begin
				group_value_q  <= '0;
				group_digits_q <= '0;
			end else begin
				group_value_q  <= next_value;
				group_digits_q <= next_digits;
			end
		end
	end

endmodule

// ----- src/brtc_queue.sv -----
`timescale 1ns / 1ps
// Small command FIFO between the front and back ends.
// Depends on brtc_pkg for the command type.
module brtc_queue #(
	parameter int DEPTH = brtc_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  brtc_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output brtc_pkg::cmd_t head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	brtc_pkg::cmd_t   entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/brtc_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the queue head into the output register one character per
// cycle unless stalled. Depends on brtc_pkg, brtc_out_if, assertion macros.
`include "byte_radix_text_codec_macros.svh"

module brtc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  brtc_pkg::cmd_t head_cmd,
	output logic           pop,
	brtc_out_if.source     out_ch
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic       load;
	logic [7:0] cur_char;
	logic       cur_last;

	always_comb begin
		if (!head_cmd.is_encode) begin
			cur_char = head_cmd.data;
			cur_last = 1'b1;
		end else if (idx_q < head_cmd.width) begin
			cur_char = brtc_pkg::digit_char(head_cmd.digits[idx_q[2:0]]);
			cur_last = 1'b0;
		end else begin
			cur_char = brtc_pkg::CHAR_SPACE;
			cur_last = 1'b1;
		end
	end

	assign load = head_valid && (!out_valid_q || out_ch.ready);
	assign pop  = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= cur_last ? 4'd0 : idx_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= cur_char;
			out_last_q <= cur_last;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_char = out_char_q;
	assign out_ch.last     = out_last_q;

	`BRTC_ASSERT_IMP(a_idx_in_range, clk, arst_n, head_valid && head_cmd.is_encode, idx_q <= head_cmd.width)
	`BRTC_ASSERT_IMP(a_decode_single, clk, arst_n, head_valid && !head_cmd.is_encode, idx_q == 4'd0)
	`BRTC_ASSERT_NXT(a_pop_rewinds, clk, arst_n, pop, idx_q == 4'd0 && out_valid_q && out_last_q)

endmodule

// ----- src/byte_radix_text_codec.sv -----
`timescale 1ns / 1ps
// Top level of the byte radix text codec: configuration registers and the
// front end, command queue and back end. Depends on brtc_pkg and the stream interfaces.
//
//   Channel   Dir   Payload              Handshake
//   in_ch     in    in_byte[7:0]         valid/ready, transfer when both high
//   out_ch    out   out_char[7:0], last  valid/ready, transfer when both high
//   cfg       in    cfg_idx, cfg_wdata   cfg_we, written on the clock edge
//
// An encoded byte yields its digits and a trailing space at one character per
// cycle while out_ch.ready allows: 9 characters in binary, 4 in octal or
// decimal, 3 in hexadecimal. A completed decode group yields one character.
// The back end's single output register sets this rate, one character a cycle.
// Reset clears the decode group, empties the queue and selects hex encode.
// A stalled output fills the queue, after which in_ch.ready drops.

module byte_radix_text_codec #(
	parameter int QUEUE_DEPTH = brtc_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	brtc_in_if.sink                          in_ch,
	brtc_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [brtc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [brtc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	// Configuration registers. The user must make writes only while the codec is
	// idle, so the front end can read them directly; the block does not enforce it.
	logic [1:0] radix_mode_q;
	logic       direction_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_mode_q <= brtc_pkg::MODE_HEX;
			direction_q  <= brtc_pkg::DIR_ENCODE;
		end else if (cfg_we) begin
			case (cfg_idx)
				brtc_pkg::REG_RADIX_MODE: radix_mode_q <= cfg_wdata[1:0];
				brtc_pkg::REG_DIRECTION:  direction_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Command path: the front end pushes one command per encoded byte or
	// finished decode group, and the back end drains them one character at
	// a time.
	logic           push;
	brtc_pkg::cmd_t push_cmd;
	logic           pop;
	logic           q_full;
	logic           head_valid;
	brtc_pkg::cmd_t head_cmd;

	brtc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.radix_mode (radix_mode_q),
		.direction  (direction_q),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	brtc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	brtc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule
